>>> hw/rtl/greedy_iou_box_matcher_unit_defines.svh
// Assertion helpers used by the matcher back end.
`ifndef GREEDY_IOU_BOX_MATCHER_UNIT_DEFINES_SVH
`define GREEDY_IOU_BOX_MATCHER_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define GBM_ASSERT_IMP(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("matcher assertion failed");

// Condition holds in the cycle after the trigger.
`define GBM_ASSERT_NXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("matcher assertion failed");

`endif

>>> hw/rtl/gbm_pkg.sv
`default_nettype none

package gbm_pkg;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;
    localparam int IDX_BITS    = 4;
    localparam int IN_COORD_BITS = 12;

    // Operation codes of an input item.
    localparam logic [OP_BITS-1:0] OP_LOAD_DET = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_TRK = 2'd1;
    localparam logic [OP_BITS-1:0] OP_MATCH    = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NONE     = 2'd3;

    // Status codes of a result item.
    localparam logic [STATUS_BITS-1:0] ST_PAIRED  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_TRK_UNP = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_DET_UNP = 2'd2;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic               valid;
        logic [OP_BITS-1:0] op;
    } t_head;

endpackage

`default_nettype wire

>>> hw/rtl/gbm_front.sv
`default_nettype none

module gbm_front #(
    parameter int BOXW = 48
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic [gbm_pkg::OP_BITS-1:0] i_op,
    input  wire logic [BOXW-1:0]             i_box,
    input  wire logic                        i_pop,
    output gbm_pkg::t_head                   o_head,
    output logic [BOXW-1:0]                  o_box
);

    logic [gbm_pkg::OP_BITS-1:0] r_qop [0:1];
    logic [BOXW-1:0]             r_qbox [0:1];
    logic                        r_wp;
    logic                        r_rp;
    logic [1:0]                  r_cnt;
    logic                        push;
    logic                        pop;

    // Unused op codes are accepted and dropped here.
    assign o_busy = (r_cnt == 2'd2);
    assign push   = i_start && !o_busy && (i_op != gbm_pkg::OP_NONE);
    assign pop    = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.op    = r_qop[r_rp];
    assign o_box        = r_qbox[r_rp];

    // Two-entry queue between the accept side and the executing side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_qop[r_wp]  <= i_op;
                r_qbox[r_wp] <= i_box;
                r_wp         <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbm_back.sv
`default_nettype none
`include "greedy_iou_box_matcher_unit_defines.svh"

module gbm_back #(
    parameter int MAX_D = 16,
    parameter int MAX_T = 16,
    parameter int CB    = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire gbm_pkg::t_head                  i_head,
    input  wire logic [4*CB-1:0]                 i_box,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic [gbm_pkg::STATUS_BITS-1:0]      o_status,
    output logic [gbm_pkg::IDX_BITS-1:0]         o_track_index,
    output logic [gbm_pkg::IDX_BITS-1:0]         o_detection_index,
    output logic                                 o_last
);

    localparam int DIW = (MAX_D > 1) ? $clog2(MAX_D) : 1;
    localparam int TIW = (MAX_T > 1) ? $clog2(MAX_T) : 1;
    localparam int DCW = $clog2(MAX_D + 1);
    localparam int TCW = $clog2(MAX_T + 1);
    localparam int AW  = 2 * CB;
    localparam int UW  = AW + 1;
    localparam int H   = (UW + 1) / 2;
    localparam int PW  = AW + UW;
    localparam int IW  = gbm_pkg::IDX_BITS;
    localparam int SW  = gbm_pkg::STATUS_BITS;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_ISSUE  = 11'b000_0000_0010,
        S_SPAN   = 11'b000_0000_0100,
        S_AREA   = 11'b000_0000_1000,
        S_UNION  = 11'b000_0001_0000,
        S_MUL    = 11'b000_0010_0000,
        S_CMP    = 11'b000_0100_0000,
        S_PASS   = 11'b000_1000_0000,
        S_UNP_T  = 11'b001_0000_0000,
        S_UNP_D  = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } t_state;

    function automatic logic [CB-1:0] span(input logic [CB-1:0] lo, input logic [CB-1:0] hi);
        return (hi >= lo) ? (hi - lo) : '0;
    endfunction

    t_state          r_st;
    logic [4*CB-1:0] r_dmem [0:MAX_D-1];
    logic [4*CB-1:0] r_tmem [0:MAX_T-1];
    logic [4*CB-1:0] r_drd;
    logic [4*CB-1:0] r_trd;
    logic [DCW-1:0]  r_dcnt;
    logic [TCW-1:0]  r_tcnt;
    logic [MAX_D-1:0] r_dtk;
    logic [MAX_T-1:0] r_ttk;
    logic [DCW-1:0]  r_d;
    logic [TCW-1:0]  r_t;
    logic [DCW-1:0]  r_bd;
    logic [TCW-1:0]  r_bt;
    logic            r_found;
    logic [AW-1:0]   r_bi;
    logic [UW-1:0]   r_bu;
    logic [CB-1:0]   r_wa, r_ha, r_wc, r_hc, r_wi, r_hi;
    logic [AW-1:0]   r_sa, r_sc, r_si;
    logic [AW-1:0]   r_in;
    logic [UW-1:0]   r_un;
    logic [1:0]      r_k;
    logic [PW-1:0]   r_p1, r_p2;
    logic            r_pv;
    logic [SW-1:0]   r_pst;
    logic [IW-1:0]   r_pti, r_pdi;
    logic            r_ov;
    logic [SW-1:0]   r_ost;
    logic [IW-1:0]   r_oti, r_odi;
    logic            r_olast;

    logic [CB-1:0]   dl, dt, dr, db, tl, tt, tr, tb;
    logic            t_wrap;
    logic [UW-1:0]   m_a;
    logic [H-1:0]    m_b;
    logic [UW+H-1:0] m_p;
    logic            prod_en;
    logic [SW-1:0]   prod_st;
    logic [IW-1:0]   prod_ti, prod_di;

    assign o_pop = i_head.valid && (r_st == S_IDLE);

    assign {dl, dt, dr, db} = r_drd;
    assign {tl, tt, tr, tb} = r_trd;

    // The next track index runs off the end of the loaded tracks.
    assign t_wrap = ({1'b0, r_t} + (TCW+1)'(1)) >= {1'b0, r_tcnt};

    // Shared multiplier: the two cross products are built from half-width parts.
    always_comb begin
        unique case (r_k)
            2'd0: begin
                m_a = UW'(r_in);
                m_b = r_bu[H-1:0];
            end
            2'd1: begin
                m_a = UW'(r_in);
                m_b = H'(r_bu[UW-1:H]);
            end
            2'd2: begin
                m_a = UW'(r_bi);
                m_b = r_un[H-1:0];
            end
            default: begin
                m_a = UW'(r_bi);
                m_b = H'(r_un[UW-1:H]);
            end
        endcase
        m_p = (UW+H)'(m_a) * (UW+H)'(m_b);
    end

    // Result items produced by the sequencer in emission order.
    always_comb begin
        prod_en = 1'b0;
        prod_st = gbm_pkg::ST_PAIRED;
        prod_ti = '0;
        prod_di = '0;
        unique case (r_st)
            S_PASS: begin
                prod_en = r_found;
                prod_ti = IW'(r_bt);
                prod_di = IW'(r_bd);
            end
            S_UNP_T: begin
                prod_en = (r_t < r_tcnt) && !r_ttk[r_t[TIW-1:0]];
                prod_st = gbm_pkg::ST_TRK_UNP;
                prod_ti = IW'(r_t);
            end
            S_UNP_D: begin
                prod_en = (r_d < r_dcnt) && !r_dtk[r_d[DIW-1:0]];
                prod_st = gbm_pkg::ST_DET_UNP;
                prod_di = IW'(r_d);
            end
            default: begin
                prod_en = 1'b0;
            end
        endcase
    end

    // Box stores with registered reads.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == gbm_pkg::OP_LOAD_DET && r_dcnt < DCW'(MAX_D)) begin
            r_dmem[r_dcnt[DIW-1:0]] <= i_box;
        end
        if (o_pop && i_head.op == gbm_pkg::OP_LOAD_TRK && r_tcnt < TCW'(MAX_T)) begin
            r_tmem[r_tcnt[TIW-1:0]] <= i_box;
        end
        r_drd <= r_dmem[r_d[DIW-1:0]];
        r_trd <= r_tmem[r_t[TIW-1:0]];
    end

    // Datapath of one pair evaluation.
    always_ff @(posedge i_clk) begin
        r_wa <= span(dl, dr);
        r_ha <= span(dt, db);
        r_wc <= span(tl, tr);
        r_hc <= span(tt, tb);
        r_wi <= span((dl > tl) ? dl : tl, (dr < tr) ? dr : tr);
        r_hi <= span((dt > tt) ? dt : tt, (db < tb) ? db : tb);
        r_sa <= AW'(r_wa) * AW'(r_ha);
        r_sc <= AW'(r_wc) * AW'(r_hc);
        r_si <= AW'(r_wi) * AW'(r_hi);
        if (r_st == S_UNION) begin
            r_in <= r_si;
            r_un <= {1'b0, r_sa} + {1'b0, r_sc} - {1'b0, r_si};
        end
        if (r_st == S_MUL) begin
            unique case (r_k)
                2'd0:    r_p1 <= PW'(m_p);
                2'd1:    r_p1 <= r_p1 + (PW'(m_p) << H);
                2'd2:    r_p2 <= PW'(m_p);
                default: r_p2 <= r_p2 + (PW'(m_p) << H);
            endcase
        end
    end

    // Sequencer: loads, greedy passes, unpaired sweeps, then wrap-up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_dcnt  <= '0;
            r_tcnt  <= '0;
            r_dtk   <= '0;
            r_ttk   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
            r_k     <= '0;
            r_d     <= '0;
            r_t     <= '0;
        end else begin
            r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (o_pop) begin
                        priority if (i_head.op == gbm_pkg::OP_LOAD_DET) begin
                            if (r_dcnt < DCW'(MAX_D)) r_dcnt <= r_dcnt + DCW'(1);
                        end else if (i_head.op == gbm_pkg::OP_LOAD_TRK) begin
                            if (r_tcnt < TCW'(MAX_T)) r_tcnt <= r_tcnt + TCW'(1);
                        end else begin
                            r_d     <= '0;
                            r_t     <= '0;
                            r_found <= 1'b0;
                            r_bi    <= '0;
                            r_bu    <= UW'(1);
                            r_st    <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    priority if (r_d >= r_dcnt) begin
                        r_st <= S_PASS;
                    end else if (r_dtk[r_d[DIW-1:0]] || r_t >= r_tcnt) begin
                        r_d <= r_d + DCW'(1);
                        r_t <= '0;
                    end else if (r_ttk[r_t[TIW-1:0]]) begin
                        if (t_wrap) begin
                            r_d <= r_d + DCW'(1);
                            r_t <= '0;
                        end else begin
                            r_t <= r_t + TCW'(1);
                        end
                    end else begin
                        r_st <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_st <= S_AREA;
                end
                S_AREA: begin
                    r_st <= S_UNION;
                end
                S_UNION: begin
                    // A pair with no intersection is never picked.
                    if (r_si == '0) begin
                        if (t_wrap) begin
                            r_d <= r_d + DCW'(1);
                            r_t <= '0;
                        end else begin
                            r_t <= r_t + TCW'(1);
                        end
                        r_st <= S_ISSUE;
                    end else begin
                        r_k  <= '0;
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) r_st <= S_CMP;
                end
                S_CMP: begin
                    // Strictly greater keeps the earliest pair on ties.
                    if (r_p1 > r_p2) begin
                        r_bi    <= r_in;
                        r_bu    <= r_un;
                        r_bd    <= r_d;
                        r_bt    <= r_t;
                        r_found <= 1'b1;
                    end
                    if (t_wrap) begin
                        r_d <= r_d + DCW'(1);
                        r_t <= '0;
                    end else begin
                        r_t <= r_t + TCW'(1);
                    end
                    r_st <= S_ISSUE;
                end
                S_PASS: begin
                    r_d <= '0;
                    r_t <= '0;
                    if (r_found) begin
                        r_dtk[r_bd[DIW-1:0]] <= 1'b1;
                        r_ttk[r_bt[TIW-1:0]] <= 1'b1;
                        r_found <= 1'b0;
                        r_bi    <= '0;
                        r_bu    <= UW'(1);
                        r_st    <= S_ISSUE;
                    end else begin
                        r_st <= S_UNP_T;
                    end
                end
                S_UNP_T: begin
                    if (r_t >= r_tcnt) begin
                        r_st <= S_UNP_D;
                    end else begin
                        r_t <= r_t + TCW'(1);
                    end
                end
                S_UNP_D: begin
                    if (r_d >= r_dcnt) begin
                        r_st <= S_FINISH;
                    end else begin
                        r_d <= r_d + DCW'(1);
                    end
                end
                S_FINISH: begin
                    r_dcnt <= '0;
                    r_tcnt <= '0;
                    r_dtk  <= '0;
                    r_ttk  <= '0;
                    r_pv   <= 1'b0;
                    r_st   <= S_IDLE;
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase

            // One result is held back so the final one can carry the last flag.
            if (prod_en) begin
                r_pv  <= 1'b1;
                r_pst <= prod_st;
                r_pti <= prod_ti;
                r_pdi <= prod_di;
            end
            if ((prod_en || r_st == S_FINISH) && r_pv) begin
                r_ov    <= 1'b1;
                r_ost   <= r_pst;
                r_oti   <= r_pti;
                r_odi   <= r_pdi;
                r_olast <= (r_st == S_FINISH);
            end
        end
    end

    assign o_valid           = r_ov;
    assign o_status          = r_ost;
    assign o_track_index     = r_oti;
    assign o_detection_index = r_odi;
    assign o_last            = r_olast;

    `GBM_ASSERT_IMP(a_taken_balanced, 1'b1, $countones(r_dtk) == $countones(r_ttk))
    `GBM_ASSERT_IMP(a_last_clears, r_ov && r_olast, r_dcnt == '0 && r_tcnt == '0)
    `GBM_ASSERT_IMP(a_mul_overlap, r_st == S_MUL, r_in != '0)
    `GBM_ASSERT_NXT(a_pass_restart, r_st == S_PASS && r_found, r_st == S_ISSUE && !r_found)

endmodule

`default_nettype wire

>>> hw/rtl/greedy_iou_box_matcher_unit.sv
// Load items are taken one per cycle while busy is low and are stored when the idle back end pops them from the queue.
// A match scans every untaken pair once per greedy pass; a pair without overlap skips the multiply,
// and an overlapping pair goes through the shared multiplier (4 steps).
// Results leave one per strobe as each pass ends and during the sweeps; the receiver cannot stall.
// Synchronous active-low reset clears counts, taken masks and the queue; stores keep data.
`default_nettype none

module greedy_iou_box_matcher_unit #(
    parameter int MAX_DETECTIONS = 16,
    parameter int MAX_TRACKS     = 16,
    parameter int COORD_BITS     = 12
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [gbm_pkg::OP_BITS-1:0]         i_op,
    input  wire logic [gbm_pkg::IN_COORD_BITS-1:0]   i_left,
    input  wire logic [gbm_pkg::IN_COORD_BITS-1:0]   i_top,
    input  wire logic [gbm_pkg::IN_COORD_BITS-1:0]   i_right,
    input  wire logic [gbm_pkg::IN_COORD_BITS-1:0]   i_bottom,
    output logic                                     o_valid,
    output logic [gbm_pkg::STATUS_BITS-1:0]          o_status,
    output logic [gbm_pkg::IDX_BITS-1:0]             o_track_index,
    output logic [gbm_pkg::IDX_BITS-1:0]             o_detection_index,
    output logic                                     o_last
);

    localparam int CB = COORD_BITS;

    logic [4*CB-1:0] box_in;
    logic [4*CB-1:0] box_q;
    gbm_pkg::t_head  head;
    logic            pop;

    // Coordinates are fitted to the internal width.
    assign box_in = {CB'(i_left), CB'(i_top), CB'(i_right), CB'(i_bottom)};

    gbm_front #(
        .BOXW (4 * CB)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_op    (i_op),
        .i_box   (box_in),
        .i_pop   (pop),
        .o_head  (head),
        .o_box   (box_q)
    );

    gbm_back #(
        .MAX_D (MAX_DETECTIONS),
        .MAX_T (MAX_TRACKS),
        .CB    (CB)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .i_box             (box_q),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_track_index     (o_track_index),
        .o_detection_index (o_detection_index),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire
